// File: rtl/core/ssr_pkg.sv
// Shared constants, types and codes of the subpixel span renderer.
package ssr_pkg;

  // Strip geometry and fixed point format.
  localparam int STRIP_LENGTH  = 64;
  localparam int FRACTION_BITS = 8;
  localparam int ONE_UNIT      = 1 << FRACTION_BITS;
  localparam int END_POS       = STRIP_LENGTH << FRACTION_BITS;

  // Field widths fixed by the ports.
  localparam int POS_W = 15;
  localparam int CH_W  = 8;
  localparam int PIX_W = 6;
  localparam int NUM_CH = 3;

  // Span arithmetic widths.
  localparam int END_W  = $clog2(END_POS + 1);
  localparam int SPAN_W = (END_W > POS_W) ? END_W : POS_W;
  localparam int WT_W   = FRACTION_BITS + 1;

  // Fade scales by (256 - amount) >> 8 regardless of the span format.
  localparam int FADE_SHIFT = 8;
  localparam int KEEP_W     = FADE_SHIFT + 1;
  localparam int MUL_W      = (WT_W > KEEP_W) ? WT_W : KEEP_W;
  localparam int PROD_W     = CH_W + MUL_W;

  // One pixel: index 2 is red, 1 is green, 0 is blue.
  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_DRAW = 2'd0,
    OP_FADE = 2'd1,
    OP_DUMP = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DRAIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic setup;
    logic issue;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic can_issue;
    logic last;
    logic busy;
  } status_t;

endpackage

// File: rtl/core/ssr_ctrl.sv
// Controller state machine that sequences one item over the frame buffer.
module ssr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       operation_i,
  output logic             in_stall_o,
  input  ssr_pkg::status_t st_i,
  output ssr_pkg::cmd_t    cmd_o
);
  import ssr_pkg::*;

  state_e state_q, state_d;
  logic   accept;
  op_e    op;

  assign op     = op_e'(operation_i);
  assign accept = in_valid_i && (state_q == ST_IDLE);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          case (op)
            OP_DRAW: state_d = ST_SETUP;
            OP_FADE: state_d = ST_RUN;
            OP_DUMP: state_d = ST_RUN;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SETUP: begin
        if (st_i.empty) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.setup = 1'b1;
          state_d     = ST_RUN;
        end
      end
      ST_RUN: begin
        if (st_i.can_issue) begin
          cmd_o.issue = 1'b1;
          if (st_i.last) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!st_i.busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/ssr_datapath.sv
// Datapath: frame buffer memory, span walker, pixel arithmetic and output register.
module ssr_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ssr_pkg::cmd_t                cmd_i,
  output ssr_pkg::status_t             st_o,
  input  logic [1:0]                   operation_i,
  input  logic [ssr_pkg::POS_W-1:0]    start_position_i,
  input  logic [ssr_pkg::POS_W-1:0]    span_length_i,
  input  logic [ssr_pkg::CH_W-1:0]     red_in_i,
  input  logic [ssr_pkg::CH_W-1:0]     green_in_i,
  input  logic [ssr_pkg::CH_W-1:0]     blue_in_i,
  input  logic [ssr_pkg::CH_W-1:0]     fade_amount_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ssr_pkg::PIX_W-1:0]    pixel_index_o,
  output logic [ssr_pkg::CH_W-1:0]     red_out_o,
  output logic [ssr_pkg::CH_W-1:0]     green_out_o,
  output logic [ssr_pkg::CH_W-1:0]     blue_out_o,
  output logic                         last_pixel_o
);
  import ssr_pkg::*;

  // Captured item.
  op_e                op_q;
  logic [POS_W-1:0]   pos_q;
  logic [POS_W-1:0]   len_q;
  pixel_t             color_q;
  logic [KEEP_W-1:0]  keep_q;

  // Walker state.
  logic [PIX_W-1:0]   pix_q;
  logic [WT_W-1:0]    w_q;
  logic [SPAN_W-1:0]  rem_q;

  // Frame buffer and per-entry valid bits.
  pixel_t             fb_mem_q [STRIP_LENGTH];
  logic [STRIP_LENGTH-1:0] vld_q;
  pixel_t             rd_data_q;
  logic               rd_vld_q;

  // Read-modify-write stage.
  logic               b_valid_q;
  logic [PIX_W-1:0]   b_addr_q;
  logic [WT_W-1:0]    b_w_q;
  logic               b_last_q;

  // Output register.
  logic               out_valid_q;
  pixel_t             out_pix_q;
  logic [PIX_W-1:0]   out_idx_q;
  logic               out_last_q;

  logic [SPAN_W-1:0]  pos_x, len_x, end_x, avail, room, head, first;
  logic               past_end;
  logic [WT_W-1:0]    step_w;
  logic               is_draw;
  pixel_t             stored, new_pix;
  logic [MUL_W-1:0]   mul_b;
  logic [PROD_W-1:0]  prod [NUM_CH];
  logic [CH_W:0]      sum  [NUM_CH];
  logic               out_take, out_load, wr_en, b_done;

  assign is_draw = (op_q == OP_DRAW);

  // Span setup: clip at the strip end and find the head pixel coverage.
  always_comb begin
    pos_x    = SPAN_W'(pos_q);
    len_x    = SPAN_W'(len_q);
    end_x    = SPAN_W'(END_POS);
    past_end = (pos_x >= end_x);
    avail    = end_x - pos_x;
    room     = (len_x < avail) ? len_x : avail;
    head     = SPAN_W'(ONE_UNIT) - SPAN_W'(pos_q[FRACTION_BITS-1:0]);
    first    = (len_x < head) ? len_x : head;
  end

  // Coverage of the pixel after the current one.
  assign step_w = (rem_q > SPAN_W'(ONE_UNIT)) ? WT_W'(ONE_UNIT) : WT_W'(rem_q);

  // Item capture and span walker.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= OP_NONE;
      pix_q <= '0;
      w_q   <= '0;
      rem_q <= '0;
    end else if (cmd_i.load) begin
      op_q  <= op_e'(operation_i);
      pix_q <= '0;
      w_q   <= '0;
      rem_q <= '0;
    end else if (cmd_i.setup) begin
      pix_q <= PIX_W'(pos_q >> FRACTION_BITS);
      w_q   <= WT_W'(first);
      rem_q <= room - first;
    end else if (cmd_i.issue) begin
      pix_q <= pix_q + PIX_W'(1);
      if (is_draw) begin
        w_q   <= step_w;
        rem_q <= rem_q - SPAN_W'(step_w);
      end
    end
  end

  // Item payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q   <= start_position_i;
      len_q   <= span_length_i;
      color_q <= {red_in_i, green_in_i, blue_in_i};
      keep_q  <= KEEP_W'(1 << FADE_SHIFT) - KEEP_W'(fade_amount_i);
    end
  end

  // Pixel arithmetic: a draw adds the scaled color with saturation, a fade scales down.
  assign stored = rd_vld_q ? rd_data_q : '0;
  assign mul_b  = is_draw ? MUL_W'(b_w_q) : MUL_W'(keep_q);

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      prod[c] = PROD_W'(is_draw ? color_q[c] : stored[c]) * PROD_W'(mul_b);
      sum[c]  = (CH_W+1)'(stored[c]) + (CH_W+1)'(CH_W'(prod[c] >> FRACTION_BITS));
      if (is_draw) begin
        new_pix[c] = sum[c][CH_W] ? {CH_W{1'b1}} : sum[c][CH_W-1:0];
      end else begin
        new_pix[c] = CH_W'(prod[c] >> FADE_SHIFT);
      end
    end
  end

  // Handshake of the read stage with the output register.
  assign out_take = out_valid_q && !out_stall_i;
  assign out_load = b_valid_q && (op_q == OP_DUMP) && (!out_valid_q || out_take);
  assign wr_en    = b_valid_q && (op_q != OP_DUMP);
  assign b_done   = wr_en || out_load;

  // Frame buffer write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fb_mem_q[b_addr_q] <= new_pix;
    end
    if (cmd_i.issue) begin
      rd_data_q <= fb_mem_q[pix_q];
    end
  end

  // Valid bits make the buffer read as black after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[b_addr_q] <= 1'b1;
      end
      if (cmd_i.issue) begin
        rd_vld_q <= vld_q[pix_q];
      end
    end
  end

  // Read stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (cmd_i.issue) begin
      b_valid_q <= 1'b1;
    end else if (b_done) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      b_addr_q <= pix_q;
      b_w_q    <= w_q;
      b_last_q <= (pix_q == PIX_W'(STRIP_LENGTH - 1));
    end
  end

  // Output register for dumped pixels.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q  <= stored;
      out_idx_q  <= b_addr_q;
      out_last_q <= b_last_q;
    end
  end

  // Status to the controller.
  assign st_o.empty     = past_end || (room == '0);
  assign st_o.can_issue = !(b_valid_q && out_valid_q && !out_take);
  assign st_o.last      = is_draw ? (rem_q == '0) : (pix_q == PIX_W'(STRIP_LENGTH - 1));
  assign st_o.busy      = b_valid_q;

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = out_idx_q;
  assign red_out_o     = out_pix_q[2];
  assign green_out_o   = out_pix_q[1];
  assign blue_out_o    = out_pix_q[0];
  assign last_pixel_o  = out_last_q;

endmodule

// File: rtl/core/subpixel_span_renderer_top.sv
// Top level of the subpixel span renderer: controller plus datapath.
//
// The block holds a 64-pixel RGB frame buffer, black after reset, and takes one item
// at a time: a draw adds an antialiased span, a fade darkens every pixel and a dump
// streams all pixels out in order with the last one flagged. The frame buffer has one
// write and one read port, so one pixel is read, modified and written back per cycle
// unless a dumped pixel held in the output register by a stalled sink stops the reads.
// A draw that covers nothing returns to idle after its setup, and an unused code is
// accepted and dropped. The next item is taken while the last dumped pixel waits in
// the output register.
module subpixel_span_renderer_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   operation_i,
  input  logic [ssr_pkg::POS_W-1:0]    start_position_i,
  input  logic [ssr_pkg::POS_W-1:0]    span_length_i,
  input  logic [ssr_pkg::CH_W-1:0]     red_in_i,
  input  logic [ssr_pkg::CH_W-1:0]     green_in_i,
  input  logic [ssr_pkg::CH_W-1:0]     blue_in_i,
  input  logic [ssr_pkg::CH_W-1:0]     fade_amount_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ssr_pkg::PIX_W-1:0]    pixel_index_o,
  output logic [ssr_pkg::CH_W-1:0]     red_out_o,
  output logic [ssr_pkg::CH_W-1:0]     green_out_o,
  output logic [ssr_pkg::CH_W-1:0]     blue_out_o,
  output logic                         last_pixel_o
);
  import ssr_pkg::*;

  cmd_t    cmd;
  status_t st;

  ssr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_stall_o  (in_stall_o),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  ssr_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .st_o             (st),
    .operation_i      (operation_i),
    .start_position_i (start_position_i),
    .span_length_i    (span_length_i),
    .red_in_i         (red_in_i),
    .green_in_i       (green_in_i),
    .blue_in_i        (blue_in_i),
    .fade_amount_i    (fade_amount_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pixel_index_o    (pixel_index_o),
    .red_out_o        (red_out_o),
    .green_out_o      (green_out_o),
    .blue_out_o       (blue_out_o),
    .last_pixel_o     (last_pixel_o)
  );

  // A pixel is only read when the read stage and output register have room.
  a_issue_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> st.can_issue)
    else $error("pixel read issued without room downstream");

  // An accepted operation keeps the input stalled while it runs.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (operation_i != OP_NONE)) |=> in_stall_o)
    else $error("input not stalled after an operation was accepted");

  // The last pixel flag marks exactly the final pixel of the strip.
  a_last_flag_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_pixel_o == (pixel_index_o == PIX_W'(STRIP_LENGTH - 1))))
    else $error("last pixel flag does not match the pixel index");

endmodule
